// File: design/iortt_pkg.sv
// ----------------------------------------------------------------------------
// iortt_pkg: shared types and constants of the I/O region translation table
// Request codes, status codes, scan modes and default sizes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package iortt_pkg;

  localparam int DEF_ENTRIES    = 32;
  localparam int DEF_ADDR_WIDTH = 32;

  localparam int FIELD_W   = 32;
  localparam int INDEX_W   = 5;
  localparam int IN_DATA_W = 136;
  localparam int OUT_DATA_W = 72;

  // request codes on the input channel
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_P2V    = 2'd1;
  localparam logic [1:0] REQ_V2P    = 2'd2;
  localparam logic [1:0] REQ_UNMAP  = 2'd3;

  // status codes on the result channel
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  // what the compare unit looks for during a scan
  typedef logic [2:0] scan_mode_t;
  localparam scan_mode_t MODE_INSERT = 3'd0;
  localparam scan_mode_t MODE_P2V    = 3'd1;
  localparam scan_mode_t MODE_V2P    = 3'd2;
  localparam scan_mode_t MODE_UNMAP  = 3'd3;
  localparam scan_mode_t MODE_COVER  = 3'd4;

endpackage

`default_nettype wire

// File: design/io_region_translation_table.sv
// An insert or a query scans the slots at most once; an unmap scans once for the
// handle and, on a hit, once more for the release check. A scan stops early at the first hit.
// Throughput: one item at a time; the scan reads one slot per cycle through a
// single memory read port and one compare unit. Reset empties all slots at once.
// ----------------------------------------------------------------------------
// io_region_translation_table: table of mapped I/O regions
// Insert, phys-to-virt and virt-to-phys lookup, and unmap by handle, each done
// by a sequenced scan over the slots with a shared compare unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module io_region_translation_table #(
  parameter int ENTRIES    = iortt_pkg::DEF_ENTRIES,
  parameter int ADDR_WIDTH = iortt_pkg::DEF_ADDR_WIDTH
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  // [1:0] req_type, [33:2] handle, [65:34] virt_address,
  // [97:66] phys_address, [129:98] region_size, [135:130] zero
  input  wire [iortt_pkg::IN_DATA_W-1:0]       in_tdata,
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  // [1:0] status, [33:2] result_addr, [38:34] entry_index,
  // [39] release_needed, [71:40] released_size
  output logic [iortt_pkg::OUT_DATA_W-1:0]     out_tdata
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int AW = ADDR_WIDTH;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_CALC = 2'd2;
  localparam logic [1:0] ST_RESP = 2'd3;

  logic [1:0]            state_r, state_nxt;
  iortt_pkg::scan_mode_t mode_r, mode_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  ev_vld_r, ev_vld_nxt;
  logic [IW-1:0]         ev_idx_r, ev_idx_nxt;

  logic [AW-1:0] req_h_r, req_h_nxt;
  logic [AW-1:0] req_va_r, req_va_nxt;
  logic [AW-1:0] req_pa_r, req_pa_nxt;
  logic [AW-1:0] req_sz_r, req_sz_nxt;
  logic [AW-1:0] hit_base_r, hit_base_nxt;
  logic [AW-1:0] hit_other_r, hit_other_nxt;

  logic [1:0]    res_status_r, res_status_nxt;
  logic [AW-1:0] res_addr_r, res_addr_nxt;
  logic [IW-1:0] res_idx_r, res_idx_nxt;
  logic          res_rel_r, res_rel_nxt;
  logic [AW-1:0] res_size_r, res_size_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r;
  logic [31:0]   out_addr_r;
  logic [4:0]    out_idx_r;
  logic          out_rel_r;
  logic [31:0]   out_size_r;

  logic [1:0]    in_type;
  logic [AW-1:0] in_h, in_va, in_pa, in_sz;
  logic          in_acc;
  logic          out_load;

  logic          tbl_we, tbl_clr;
  logic          rd_valid;
  logic [AW-1:0] rd_handle, rd_virt, rd_phys, rd_size;
  logic          match_hit;
  logic          hit_now;
  logic          issue;
  logic          scan_end;
  logic [AW-1:0] calc_key;
  logic [63:0]   addr_ext, size_ext;
  logic [15:0]   idx_ext;

  // fit a 32-bit field to the address width: truncate or zero-extend
  function automatic logic [AW-1:0] to_aw(input logic [31:0] v);
    logic [63:0] wide;
    wide = 64'(v);
    return wide[AW-1:0];
  endfunction

  always_comb begin
    in_type = in_tdata[1:0];
    in_h    = to_aw(in_tdata[33:2]);
    in_va   = to_aw(in_tdata[65:34]);
    in_pa   = to_aw(in_tdata[97:66]);
    in_sz   = to_aw(in_tdata[129:98]);
  end

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  iortt_table #(
    .ENTRIES    (ENTRIES),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .raddr     (cnt_r[IW-1:0]),
    .we        (tbl_we),
    .clr       (tbl_clr),
    .waddr     (ev_idx_r),
    .wr_handle (req_h_r),
    .wr_virt   (req_va_r),
    .wr_phys   (req_pa_r),
    .wr_size   (req_sz_r),
    .rd_valid  (rd_valid),
    .rd_handle (rd_handle),
    .rd_virt   (rd_virt),
    .rd_phys   (rd_phys),
    .rd_size   (rd_size)
  );

  iortt_match #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_match (
    .mode        (mode_r),
    .slot_valid  (rd_valid),
    .slot_handle (rd_handle),
    .slot_virt   (rd_virt),
    .slot_phys   (rd_phys),
    .slot_size   (rd_size),
    .req_handle  (req_h_r),
    .req_virt    (req_va_r),
    .req_phys    (req_pa_r),
    .hit         (match_hit)
  );

  assign hit_now  = (state_r == ST_SCAN) && ev_vld_r && match_hit;
  assign scan_end = (state_r == ST_SCAN) && !ev_vld_r && (cnt_r == CW'(ENTRIES));
  assign issue    = (state_r == ST_SCAN) && !hit_now && (cnt_r < CW'(ENTRIES));
  assign calc_key = (mode_r == iortt_pkg::MODE_P2V) ? req_pa_r : req_va_r;
  assign out_load = (state_r == ST_RESP) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    cnt_nxt        = cnt_r;
    ev_vld_nxt     = 1'b0;
    ev_idx_nxt     = ev_idx_r;
    req_h_nxt      = req_h_r;
    req_va_nxt     = req_va_r;
    req_pa_nxt     = req_pa_r;
    req_sz_nxt     = req_sz_r;
    hit_base_nxt   = hit_base_r;
    hit_other_nxt  = hit_other_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    res_idx_nxt    = res_idx_r;
    res_rel_nxt    = res_rel_r;
    res_size_nxt   = res_size_r;
    tbl_we         = 1'b0;
    tbl_clr        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          req_h_nxt      = in_h;
          req_va_nxt     = in_va;
          req_pa_nxt     = in_pa;
          req_sz_nxt     = in_sz;
          mode_nxt       = iortt_pkg::scan_mode_t'({1'b0, in_type});
          cnt_nxt        = '0;
          res_status_nxt = iortt_pkg::STAT_MISS;
          res_addr_nxt   = '0;
          res_idx_nxt    = '0;
          res_rel_nxt    = 1'b0;
          res_size_nxt   = '0;
          // a zero handle is refused: drop the insert and answer with a miss
          if (in_type == iortt_pkg::REQ_INSERT && in_h == '0) begin
            state_nxt = ST_RESP;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (hit_now) begin
          unique case (mode_r)
            iortt_pkg::MODE_INSERT: begin
              tbl_we         = 1'b1;
              res_status_nxt = iortt_pkg::STAT_OK;
              res_idx_nxt    = ev_idx_r;
              state_nxt      = ST_RESP;
            end
            iortt_pkg::MODE_P2V: begin
              hit_base_nxt   = rd_phys;
              hit_other_nxt  = rd_virt;
              res_status_nxt = iortt_pkg::STAT_OK;
              res_idx_nxt    = ev_idx_r;
              state_nxt      = ST_CALC;
            end
            iortt_pkg::MODE_V2P: begin
              hit_base_nxt   = rd_virt;
              hit_other_nxt  = rd_phys;
              res_status_nxt = iortt_pkg::STAT_OK;
              res_idx_nxt    = ev_idx_r;
              state_nxt      = ST_CALC;
            end
            iortt_pkg::MODE_UNMAP: begin
              // free the slot, then rescan for the release check
              tbl_clr        = 1'b1;
              res_status_nxt = iortt_pkg::STAT_OK;
              res_idx_nxt    = ev_idx_r;
              res_addr_nxt   = rd_virt;
              res_size_nxt   = rd_size;
              mode_nxt       = iortt_pkg::MODE_COVER;
              cnt_nxt        = '0;
            end
            iortt_pkg::MODE_COVER: begin
              res_rel_nxt = 1'b0;
              state_nxt   = ST_RESP;
            end
            default: begin
              state_nxt = ST_RESP;
            end
          endcase
        end else if (scan_end) begin
          if (mode_r == iortt_pkg::MODE_INSERT) begin
            res_status_nxt = iortt_pkg::STAT_FULL;
          end
          if (mode_r == iortt_pkg::MODE_COVER) begin
            res_rel_nxt = 1'b1;
          end
          state_nxt = ST_RESP;
        end else if (issue) begin
          cnt_nxt    = cnt_r + CW'(1);
          ev_vld_nxt = 1'b1;
          ev_idx_nxt = cnt_r[IW-1:0];
        end
      end
      ST_CALC: begin
        res_addr_nxt = hit_other_r + (calc_key - hit_base_r);
        state_nxt    = ST_RESP;
      end
      ST_RESP: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    addr_ext = 64'(res_addr_r);
    size_ext = 64'(res_size_r);
    idx_ext  = 16'(res_idx_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= iortt_pkg::MODE_INSERT;
      cnt_r       <= '0;
      ev_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      cnt_r       <= cnt_nxt;
      ev_vld_r    <= ev_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ev_idx_r     <= ev_idx_nxt;
    req_h_r      <= req_h_nxt;
    req_va_r     <= req_va_nxt;
    req_pa_r     <= req_pa_nxt;
    req_sz_r     <= req_sz_nxt;
    hit_base_r   <= hit_base_nxt;
    hit_other_r  <= hit_other_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    res_idx_r    <= res_idx_nxt;
    res_rel_r    <= res_rel_nxt;
    res_size_r   <= res_size_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_addr_r   <= addr_ext[31:0];
      out_idx_r    <= idx_ext[4:0];
      out_rel_r    <= res_rel_r;
      out_size_r   <= size_ext[31:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_size_r, out_rel_r, out_idx_r, out_addr_r, out_status_r};

  // scan counter never runs past the table
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(ENTRIES))
    else $error("scan counter beyond table size");

  // an accepted item always leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != ST_IDLE))
    else $error("accepted item did not start work");

  // slot evaluation only happens inside a scan
  a_eval_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ev_vld_r |-> (state_r == ST_SCAN))
    else $error("slot evaluated outside a scan");

  // table is written or cleared only on a scan hit
  a_write_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (tbl_we || tbl_clr) |-> hit_now)
    else $error("table changed without a hit");

  // a result is loaded only from the response state and never reports status 3
  a_load_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_tdata[1:0] != 2'd3))
    else $error("invalid status loaded");

endmodule

`default_nettype wire

// File: design/iortt_match.sv
// ----------------------------------------------------------------------------
// iortt_match: slot compare unit
// Checks one table slot against the current request: free slot, range
// coverage of an address, or handle equality.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iortt_match #(
  parameter int ADDR_WIDTH = iortt_pkg::DEF_ADDR_WIDTH
) (
  input  wire iortt_pkg::scan_mode_t  mode,
  input  wire                         slot_valid,
  input  wire [ADDR_WIDTH-1:0]        slot_handle,
  input  wire [ADDR_WIDTH-1:0]        slot_virt,
  input  wire [ADDR_WIDTH-1:0]        slot_phys,
  input  wire [ADDR_WIDTH-1:0]        slot_size,
  input  wire [ADDR_WIDTH-1:0]        req_handle,
  input  wire [ADDR_WIDTH-1:0]        req_virt,
  input  wire [ADDR_WIDTH-1:0]        req_phys,
  output logic                        hit
);

  logic [ADDR_WIDTH-1:0] base;
  logic [ADDR_WIDTH-1:0] key;
  logic [ADDR_WIDTH-1:0] bound;
  logic                  covered;

  always_comb begin
    base = (mode == iortt_pkg::MODE_P2V) ? slot_phys : slot_virt;
    if (mode == iortt_pkg::MODE_P2V) begin
      key = req_phys;
    end else if (mode == iortt_pkg::MODE_V2P) begin
      key = req_virt;
    end else begin
      key = req_handle;
    end
    // bound wraps modulo 2^ADDR_WIDTH, so a wrapping region covers nothing
    bound   = base + slot_size;
    covered = (base <= key) && (bound > key);
  end

  always_comb begin
    unique case (mode)
      iortt_pkg::MODE_INSERT: hit = !slot_valid;
      iortt_pkg::MODE_UNMAP:  hit = slot_valid && (slot_handle == req_handle);
      iortt_pkg::MODE_P2V,
      iortt_pkg::MODE_V2P,
      iortt_pkg::MODE_COVER:  hit = slot_valid && covered;
      default:                hit = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// File: design/iortt_table.sv
// ----------------------------------------------------------------------------
// iortt_table: slot storage
// One memory holding handle, virtual base, physical base and size per slot,
// with a valid flag per slot; an invalid slot reads as all zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iortt_table #(
  parameter int ENTRIES    = iortt_pkg::DEF_ENTRIES,
  parameter int ADDR_WIDTH = iortt_pkg::DEF_ADDR_WIDTH,
  localparam int IW        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire [IW-1:0]           raddr,
  input  wire                    we,
  input  wire                    clr,
  input  wire [IW-1:0]           waddr,
  input  wire [ADDR_WIDTH-1:0]   wr_handle,
  input  wire [ADDR_WIDTH-1:0]   wr_virt,
  input  wire [ADDR_WIDTH-1:0]   wr_phys,
  input  wire [ADDR_WIDTH-1:0]   wr_size,
  output logic                   rd_valid,
  output logic [ADDR_WIDTH-1:0]  rd_handle,
  output logic [ADDR_WIDTH-1:0]  rd_virt,
  output logic [ADDR_WIDTH-1:0]  rd_phys,
  output logic [ADDR_WIDTH-1:0]  rd_size
);

  localparam int DW = 4 * ADDR_WIDTH;

  logic [DW-1:0]      mem_r [ENTRIES];
  logic [ENTRIES-1:0] valid_r;
  logic [DW-1:0]      rd_data_r;
  logic               rd_valid_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= {wr_size, wr_phys, wr_virt, wr_handle};
    end
    rd_data_r <= mem_r[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (we) begin
        valid_r[waddr] <= 1'b1;
      end else if (clr) begin
        valid_r[waddr] <= 1'b0;
      end
      rd_valid_r <= valid_r[raddr];
    end
  end

  always_comb begin
    rd_valid  = rd_valid_r;
    rd_handle = rd_valid_r ? rd_data_r[ADDR_WIDTH-1:0] : '0;
    rd_virt   = rd_valid_r ? rd_data_r[2*ADDR_WIDTH-1:ADDR_WIDTH] : '0;
    rd_phys   = rd_valid_r ? rd_data_r[3*ADDR_WIDTH-1:2*ADDR_WIDTH] : '0;
    rd_size   = rd_valid_r ? rd_data_r[4*ADDR_WIDTH-1:3*ADDR_WIDTH] : '0;
  end

endmodule

`default_nettype wire
